/* sv/byte_histogram_mode_finder_defines.svh */
// Assertion macros shared by the byte histogram mode finder RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef BYTE_HISTOGRAM_MODE_FINDER_DEFINES_SVH
`define BYTE_HISTOGRAM_MODE_FINDER_DEFINES_SVH
`ifndef SYNTH
`define BHM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("byte histogram mode finder: assertion failed");
`define BHM_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("byte histogram mode finder: assertion failed");
`else
`define BHM_ASSERT(lbl, prop)
`define BHM_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

/* sv/bhm_pkg.sv */
// Package of the byte histogram mode finder: widths, beat types, states and
// the command and status groups between controller and datapath. No dependencies.
package bhm_pkg;

    localparam int SYMBOL_COUNT_DEF = 256;
    localparam int COUNT_BITS_DEF   = 24;

    localparam int SYM_W   = 8;
    localparam int IDX_W   = 8;
    localparam int CHUNK_W = 2;
    localparam int MASK_W  = 64;
    localparam int OFS_W   = 6;
    localparam int PEAK_W  = 24;

    localparam logic [CHUNK_W-1:0] CHUNK_LAST = 2'd3;
    localparam logic [OFS_W-1:0]   OFS_LAST   = 6'h3F;
    localparam logic [PEAK_W-1:0]  PEAK_MAX   = 24'hFF_FFFF;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             end_of_stream;
    } t_in_beat;

    typedef struct packed {
        logic [CHUNK_W-1:0] chunk_index;
        logic [MASK_W-1:0]  mode_mask;
        logic [PEAK_W-1:0]  peak_count;
        logic               final_chunk;
    } t_out_beat;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE,
        ST_SCAN,
        ST_FLUSH,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic rd_sym;
        logic upd;
        logic idx_zero;
        logic clr_step;
        logic scan_step;
        logic out_load;
        logic peak_zero;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
        logic chunk_end;
        logic final_chunk;
        logic last_flag;
        logic out_free;
    } t_dp_sts;

endpackage

/* sv/bhm_in_if.sv */
// Input channel of the byte histogram mode finder: one byte per beat.
// Depends on bhm_pkg.
interface bhm_in_if import bhm_pkg::*;;
    logic     valid;
    logic     ready;
    t_in_beat data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

/* sv/bhm_out_if.sv */
// Result channel of the byte histogram mode finder: one mask chunk per beat.
// Depends on bhm_pkg.
interface bhm_out_if import bhm_pkg::*;;
    logic      valid;
    logic      ready;
    t_out_beat data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

/* sv/byte_histogram_mode_finder.sv */
// Byte histogram mode finder, top level: counts byte values per stream and
// reports which values reach the peak count. Depends on bhm_pkg, the channel
// interfaces, bhm_ctrl and bhm_dp.
//
// Usage. Bytes arrive on i_in, one per beat; the beat with end_of_stream set
// closes the stream. Each byte is read and then written back: IDLE reads its
// count from the count memory, UPDATE writes the incremented count back (a
// read-modify-write on the single memory port pair), so the input takes no new
// byte until the last one is written back. After the closing byte, four result
// beats leave on o_out, one per group of 64 byte values, chunk_index 0 to 3,
// the last with final_chunk set. Each group is scanned one entry a cycle, and
// its result is loaded when the scan of the group is through. The scan clears
// the counts and the peak is cleared with the last result, so the next stream
// may begin at once.
// After reset the block runs a clearing pass over the count memory, with
// i_in.ready low. A stalled receiver holds the result register; the scan
// waits for it, and input bytes are taken again as soon as the fourth
// result sits in the result register.
module byte_histogram_mode_finder import bhm_pkg::*; #(
    parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF,
    parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bhm_in_if.sink    i_in,
    bhm_out_if.source o_out
);

    t_dp_cmd   w_cmd;
    t_dp_sts   w_sts;
    logic      w_in_ready;
    logic      w_out_valid;
    t_out_beat w_out_data;

    bhm_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in.valid),
        .i_sts     (w_sts),
        .o_in_ready(w_in_ready),
        .o_cmd     (w_cmd)
    );

    bhm_dp #(
        .SYMBOL_COUNT(SYMBOL_COUNT),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_in_data  (i_in.data),
        .i_out_ready(o_out.ready),
        .o_sts      (w_sts),
        .o_out_valid(w_out_valid),
        .o_out_data (w_out_data)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;
    assign o_out.data  = w_out_data;

endmodule

/* sv/bhm_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module bhm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/bhm_dp.sv */
// Datapath of the byte histogram mode finder: count store, peak register,
// scan index, mask shifter and result register. Depends on bhm_pkg and bhm_ram.
`include "byte_histogram_mode_finder_defines.svh"
module bhm_dp import bhm_pkg::*; #(
    parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF,
    parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_cmd   i_cmd,
    input  t_in_beat  i_in_data,
    input  logic      i_out_ready,
    output t_dp_sts   o_sts,
    output logic      o_out_valid,
    output t_out_beat o_out_data
);

    localparam int ADDR_W = $clog2(SYMBOL_COUNT);
    localparam logic [IDX_W:0] LIMIT = (IDX_W + 1)'(SYMBOL_COUNT);

    logic [SYM_W-1:0]      r_sym;
    logic                  r_last;
    logic [IDX_W-1:0]      r_idx;
    logic [IDX_W-1:0]      r_idx_d;
    logic                  r_idx_d_in;
    logic                  r_rd_d;
    logic [COUNT_BITS-1:0] r_peak;
    logic [MASK_W-1:0]     r_mask;
    logic                  r_out_valid;
    t_out_beat             r_out;

    logic                  w_sym_in;
    logic                  w_idx_in;
    logic                  w_hit;
    logic [COUNT_BITS-1:0] w_rdata;
    logic [COUNT_BITS-1:0] w_new_count;
    logic [31:0]           w_peak_ext;
    logic [PEAK_W-1:0]     w_peak_sat;
    logic                  w_we;
    logic [ADDR_W-1:0]     w_waddr;
    logic [COUNT_BITS-1:0] w_wdata;
    logic                  w_re;
    logic [ADDR_W-1:0]     w_raddr;

    assign w_sym_in = {1'b0, r_sym} < LIMIT;
    assign w_idx_in = {1'b0, r_idx} < LIMIT;
    assign w_hit    = r_rd_d && r_idx_d_in && (w_rdata == r_peak);

    assign w_new_count = (w_rdata == {COUNT_BITS{1'b1}}) ? w_rdata
                                                          : w_rdata + 1'b1;

    assign w_peak_ext = 32'(r_peak);
    assign w_peak_sat = (w_peak_ext > 32'(PEAK_MAX)) ? PEAK_MAX
                                                      : w_peak_ext[PEAK_W-1:0];

    always_comb begin
        w_re    = 1'b0;
        w_raddr = r_idx[ADDR_W-1:0];
        if (i_cmd.rd_sym) begin
            w_re    = 1'b1;
            w_raddr = i_in_data.symbol[ADDR_W-1:0];
        end else if (i_cmd.scan_step && w_idx_in) begin
            w_re = 1'b1;
        end
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx[ADDR_W-1:0];
        w_wdata = '0;
        if (i_cmd.upd) begin
            w_we    = w_sym_in;
            w_waddr = r_sym[ADDR_W-1:0];
            w_wdata = w_new_count;
        end else if (i_cmd.clr_step) begin
            w_we = w_idx_in;
        end else if (r_rd_d) begin
            w_we    = r_idx_d_in;
            w_waddr = r_idx_d[ADDR_W-1:0];
        end
    end

    bhm_ram #(
        .WIDTH(COUNT_BITS),
        .DEPTH(SYMBOL_COUNT)
    ) u_counts (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_re   (w_re),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_rd_d      <= 1'b0;
            r_peak      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.idx_zero) begin
                r_idx <= '0;
            end else if (i_cmd.clr_step || i_cmd.scan_step) begin
                r_idx <= r_idx + 1'b1;
            end
            r_rd_d <= i_cmd.scan_step;
            if (i_cmd.peak_zero) begin
                r_peak <= '0;
            end else if (i_cmd.upd && w_sym_in && (w_new_count > r_peak)) begin
                r_peak <= w_new_count;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_sym) begin
            r_sym  <= i_in_data.symbol;
            r_last <= i_in_data.end_of_stream;
        end
        if (i_cmd.scan_step) begin
            r_idx_d    <= r_idx;
            r_idx_d_in <= w_idx_in;
        end
        if (r_rd_d) begin
            r_mask <= {w_hit, r_mask[MASK_W-1:1]};
        end
        if (i_cmd.out_load) begin
            r_out.chunk_index <= r_idx_d[IDX_W-1:OFS_W];
            r_out.mode_mask   <= r_mask;
            r_out.peak_count  <= w_peak_sat;
            r_out.final_chunk <= (r_idx_d[IDX_W-1:OFS_W] == CHUNK_LAST);
        end
    end

    assign o_sts.clear_last  = (r_idx == IDX_W'(SYMBOL_COUNT - 1));
    assign o_sts.chunk_end   = (r_idx[OFS_W-1:0] == OFS_LAST);
    assign o_sts.final_chunk = (r_idx_d[IDX_W-1:OFS_W] == CHUNK_LAST);
    assign o_sts.last_flag   = r_last;
    assign o_sts.out_free    = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `BHM_ASSERT(a_peak_covers_count,
        (i_cmd.upd && w_sym_in) |=> (r_peak >= $past(w_new_count)))
    `BHM_ASSERT(a_load_into_free_slot,
        i_cmd.out_load |-> (!r_out_valid || i_out_ready))
    `BHM_ASSERT(a_peak_cleared_after_run,
        (i_cmd.out_load && o_sts.final_chunk) |=> (r_peak == '0))

endmodule

/* sv/bhm_ctrl.sv */
// Controller of the byte histogram mode finder: sequences the clearing pass,
// count updates and the four-chunk scan. Depends on bhm_pkg.
`include "byte_histogram_mode_finder_defines.svh"
module bhm_ctrl import bhm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_dp_sts i_sts,
    output logic    o_in_ready,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clear_last) begin
                    o_cmd.idx_zero = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.rd_sym = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                o_cmd.upd = 1'b1;
                n_state   = i_sts.last_flag ? ST_SCAN : ST_IDLE;
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.chunk_end) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.peak_zero = i_sts.final_chunk;
                    n_state         = i_sts.final_chunk ? ST_IDLE : ST_SCAN;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    `BHM_ASSERT(a_clear_only_after_reset,
        (r_state != ST_CLEAR) |=> (r_state != ST_CLEAR))
    `BHM_ASSERT(a_scan_after_last_update,
        (r_state == ST_UPDATE && i_sts.last_flag) |=> (r_state == ST_SCAN))
    `BHM_ASSERT_ALWAYS(a_no_accept_in_reset,
        !i_rst_n |=> !o_in_ready)

endmodule
